// ----- src/twc_pkg.sv -----
// twc_pkg: event codes, register numbers, result struct and lookup tables
// for the triangle wave channel; depends on nothing
package twc_pkg;

    localparam logic [2:0] FUNC_WRITE   = 3'd0;
    localparam logic [2:0] FUNC_TIMER   = 3'd1;
    localparam logic [2:0] FUNC_QUARTER = 3'd2;
    localparam logic [2:0] FUNC_HALF    = 3'd3;
    localparam logic [2:0] FUNC_SILENCE = 3'd4;

    localparam logic [1:0] REG_LINEAR   = 2'd0;
    localparam logic [1:0] REG_UNUSED   = 2'd1;
    localparam logic [1:0] REG_TIMER_LO = 2'd2;
    localparam logic [1:0] REG_TIMER_HI = 2'd3;

    typedef struct packed {
        logic [3:0] sample;
        logic       length_active;
    } t_result;

    // length counter load values
    function automatic logic [7:0] length_lookup(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:  v = 8'd10;   5'd1:  v = 8'd254; 5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;   5'd5:  v = 8'd4;   5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
            5'd8:  v = 8'd160;  5'd9:  v = 8'd8;   5'd10: v = 8'd60;  5'd11: v = 8'd10;
            5'd12: v = 8'd14;   5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
            5'd16: v = 8'd12;   5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
            5'd20: v = 8'd48;   5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
            5'd24: v = 8'd192;  5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
            5'd28: v = 8'd16;   5'd29: v = 8'd28;  5'd30: v = 8'd32;  5'd31: v = 8'd30;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // 15 down to 0, then 0 up to 15
    function automatic logic [3:0] wave_lookup(input logic [4:0] pos);
        return pos[4] ? pos[3:0] : ~pos[3:0];
    endfunction

endpackage

// ----- src/twc_core.sv -----
// twc_core: channel state and the per-item event logic
// depends on twc_pkg
module twc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [2:0]       i_func,
    input  logic [1:0]       i_reg_index,
    input  logic [7:0]       i_data_byte,
    output twc_pkg::t_result o_result
);
    import twc_pkg::*;

    logic [10:0] r_period_reload, n_period_reload;
    logic [10:0] r_period_count,  n_period_count;
    logic [4:0]  r_step_position, n_step_position;
    logic [7:0]  r_length_count,  n_length_count;
    logic        r_count_enable,  n_count_enable;
    logic [6:0]  r_linear_reload, n_linear_reload;
    logic [6:0]  r_linear_count,  n_linear_count;
    logic        r_reload_pending, n_reload_pending;
    logic        r_muted, n_muted;
    logic [10:0] w_new_reload;

    assign w_new_reload = {i_data_byte[2:0], r_period_reload[7:0]};

    always_comb begin
        n_period_reload  = r_period_reload;
        n_period_count   = r_period_count;
        n_step_position  = r_step_position;
        n_length_count   = r_length_count;
        n_count_enable   = r_count_enable;
        n_linear_reload  = r_linear_reload;
        n_linear_count   = r_linear_count;
        n_reload_pending = r_reload_pending;
        n_muted          = r_muted;
        unique case (i_func)
            FUNC_WRITE: begin
                unique case (i_reg_index)
                    REG_LINEAR: begin
                        n_count_enable  = ~i_data_byte[7];
                        n_linear_reload = i_data_byte[6:0];
                    end
                    REG_UNUSED: begin
                    end
                    REG_TIMER_LO: begin
                        n_period_reload = {r_period_reload[10:8], i_data_byte};
                    end
                    REG_TIMER_HI: begin
                        n_period_reload  = w_new_reload;
                        n_period_count   = w_new_reload;
                        n_length_count   = length_lookup(i_data_byte[7:3]);
                        n_reload_pending = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            FUNC_TIMER: begin
                if (r_period_count != 11'd0) begin
                    n_period_count = r_period_count - 11'd1;
                end else begin
                    n_period_count  = r_period_reload;
                    n_step_position = r_step_position + 5'd1;
                end
            end
            FUNC_QUARTER: begin
                if (r_reload_pending) begin
                    n_linear_count = r_linear_reload;
                end else if (r_linear_count != 7'd0) begin
                    n_linear_count = r_linear_count - 7'd1;
                end
                if (r_count_enable) begin
                    n_reload_pending = 1'b0;
                end
            end
            FUNC_HALF: begin
                if (r_count_enable && r_length_count != 8'd0) begin
                    n_length_count = r_length_count - 8'd1;
                end
            end
            FUNC_SILENCE: begin
                n_length_count = 8'd0;
                n_muted        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result reflects the state after this item
    always_comb begin
        o_result.length_active = (n_length_count != 8'd0);
        if (n_muted || n_length_count == 8'd0 || n_linear_count == 7'd0) begin
            o_result.sample = 4'd0;
        end else begin
            o_result.sample = wave_lookup(n_step_position);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_reload  <= '0;
            r_period_count   <= '0;
            r_step_position  <= '0;
            r_length_count   <= '0;
            r_count_enable   <= 1'b0;
            r_linear_reload  <= '0;
            r_linear_count   <= '0;
            r_reload_pending <= 1'b0;
            r_muted          <= 1'b0;
        end else if (i_en) begin
            r_period_reload  <= n_period_reload;
            r_period_count   <= n_period_count;
            r_step_position  <= n_step_position;
            r_length_count   <= n_length_count;
            r_count_enable   <= n_count_enable;
            r_linear_reload  <= n_linear_reload;
            r_linear_count   <= n_linear_count;
            r_reload_pending <= n_reload_pending;
            r_muted          <= n_muted;
        end
    end

endmodule

// ----- src/triangle_wave_channel.sv -----
// triangle_wave_channel: top level with input handshake and result skid buffer
// depends on twc_pkg and twc_core
//
// Triangle wave sound channel. Each input item is one event: a register
// write, a timer clock, a quarter-frame clock, a half-frame clock or a
// silence command. Every item yields exactly one result item: the 4-bit
// sample and the length-active flag as they stand after that event. The
// state update and the result logic sit between the channel state
// registers and the result register, so one item can be taken every clock
// while the skid register is empty. The result path has an output register
// plus a one-entry skid register, so input is refused only while both hold
// results that the consumer has not taken. Only reset clears the silenced
// state.
module triangle_wave_channel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_func,
    input  logic [1:0] i_reg_index,
    input  logic [7:0] i_data_byte,
    // result item channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_sample,
    output logic       o_length_active
);
    import twc_pkg::*;

    logic    w_accept;
    logic    w_drain;
    t_result w_result;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // a new item is refused only when the skid entry is occupied
    assign o_in_ready = ~r_skid_valid;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_drain    = r_out_valid & i_out_ready;

    twc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_func      (i_func),
        .i_reg_index (i_reg_index),
        .i_data_byte (i_data_byte),
        .o_result    (w_result)
    );

    // output register and skid entry; order of items is kept because the
    // skid only fills when the output register is full and stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid && w_drain) begin
                // oldest waiting item moves up
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (w_accept && r_out_valid && !i_out_ready) begin
                // output stalled: park the new item
                r_skid_valid <= 1'b1;
            end else if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (w_drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid && w_drain) begin
            r_out <= r_skid;
        end else if (w_accept && !(r_out_valid && !i_out_ready)) begin
            r_out <= w_result;
        end
        if (w_accept && r_out_valid && !i_out_ready) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out.sample;
    assign o_length_active = r_out.length_active;

    // the skid entry is never used while the output register is empty
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item with empty output register");

    // an item accepted against a stalled output lands in the skid entry
    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("item accepted during stall was not parked");

    // draining with a parked item keeps a result on the output
    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_drain) |=> (r_out_valid && !r_skid_valid))
        else $error("parked item lost on drain");

    // a nonzero sample needs a running length counter
    a_sample_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sample != 4'd0) |-> r_out.length_active)
        else $error("sample not gated by length counter");

endmodule

// ----- bench/triangle_wave_channel_tb.sv -----
// triangle_wave_channel_tb: random and directed event stream against a cycle-free
// model of the triangle channel; depends on twc_pkg and triangle_wave_channel
`timescale 1ns / 100ps

module triangle_wave_channel_tb;
    import twc_pkg::*;

    // codes the block takes but does nothing with
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    // length counter load values, entry 0 first
    localparam logic [255:0] LENGTH_LOADS = {
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] reg_index;
        logic [7:0] data_byte;
    } t_chan_event;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_func = '0;
    logic [1:0] i_reg_index = '0;
    logic [7:0] i_data_byte = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_sample;
    logic       o_length_active;

    t_chan_event pending_events[$];
    t_result     expected_levels[$];

    int total_items = 0;
    int items_taken = 0;
    int results_seen = 0;
    int error_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic hold_off = 1'b0;

    // predicted channel state
    logic [10:0] tmr_reload = '0;
    logic [10:0] tmr_count = '0;
    logic [4:0]  seq_pos = '0;
    logic [7:0]  len_count = '0;
    logic        len_enable = 1'b0;
    logic [6:0]  lin_reload = '0;
    logic [6:0]  lin_count = '0;
    logic        lin_reload_flag = 1'b0;
    logic        silenced = 1'b0;

    triangle_wave_channel dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_reg_index    (i_reg_index),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample       (o_sample),
        .o_length_active(o_length_active)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_item(input logic [2:0] f, input logic [1:0] r, input logic [7:0] d);
        pending_events.push_back({f, r, d});
    endtask

    // applies one event to the predicted state and returns the level it leaves
    function automatic t_result apply_event(input t_chan_event ev);
        t_result lvl;
        int      slot;
        case (ev.func)
            FUNC_WRITE: begin
                case (ev.reg_index)
                    REG_LINEAR: begin
                        len_enable = ~ev.data_byte[7];
                        lin_reload = ev.data_byte[6:0];
                    end
                    REG_TIMER_LO: tmr_reload[7:0] = ev.data_byte;
                    REG_TIMER_HI: begin
                        tmr_reload[10:8] = ev.data_byte[2:0];
                        slot = 31 - int'(ev.data_byte[7:3]);
                        len_count = LENGTH_LOADS[slot*8 +: 8];
                        lin_reload_flag = 1'b1;
                        tmr_count = tmr_reload;
                    end
                    default: ;
                endcase
            end
            FUNC_TIMER: begin
                if (tmr_count != 0) begin
                    tmr_count = tmr_count - 11'd1;
                end else begin
                    tmr_count = tmr_reload;
                    seq_pos = seq_pos + 5'd1;
                end
            end
            FUNC_QUARTER: begin
                if (lin_reload_flag) begin
                    lin_count = lin_reload;
                end else if (lin_count != 0) begin
                    lin_count = lin_count - 7'd1;
                end
                if (len_enable) begin
                    lin_reload_flag = 1'b0;
                end
            end
            FUNC_HALF: begin
                if (len_enable && len_count != 0) begin
                    len_count = len_count - 8'd1;
                end
            end
            FUNC_SILENCE: begin
                len_count = '0;
                silenced = 1'b1;
            end
            default: ;
        endcase
        if (silenced || len_count == 0 || lin_count == 0) begin
            lvl.sample = 4'd0;
        end else begin
            // falling half first, then rising
            lvl.sample = seq_pos[4] ? seq_pos[3:0] : 4'd15 - seq_pos[3:0];
        end
        lvl.length_active = (len_count != 0);
        return lvl;
    endfunction

    // sender: holds each item until taken, idles in bursts
    always @(posedge i_clk) begin : drive_events
        t_chan_event nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_levels.push_back(apply_event({i_func, i_reg_index, i_data_byte}));
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (items_taken < total_items - 200 && (items_taken / 128) % 4 != 3
                             && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 16) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = pending_events.pop_front();
                    i_func      <= nxt.func;
                    i_reg_index <= nxt.reg_index;
                    i_data_byte <= nxt.data_byte;
                    i_in_valid  <= 1'b1;
                end
            end
        end
    end

    // receiver: checks each result against the oldest prediction
    always @(posedge i_clk) begin : check_levels
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    flag_error($sformatf("unexpected result, sample %0d", o_sample));
                end else begin
                    want = expected_levels.pop_front();
                    if (o_sample !== want.sample) begin
                        flag_error($sformatf("result %0d: sample %0d, expected %0d",
                                             results_seen, o_sample, want.sample));
                    end
                    if (o_length_active !== want.length_active) begin
                        flag_error($sformatf("result %0d: length_active %0b, expected %0b",
                                             results_seen, o_length_active,
                                             want.length_active));
                    end
                end
                results_seen++;
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else if (results_seen < total_items - 200 && (results_seen / 96) % 3 != 2
                         && $urandom_range(0, 11) == 0) begin
                recv_gap = $urandom_range(1, 16) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // long consumer stall so the skid buffer fills and input backs up
    initial begin : consumer_stall
        wait (results_seen >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("triangle_wave_channel_tb failed");
        $finish;
    end

    initial begin : run_stimulus
        logic [7:0] lin_data;
        logic [7:0] hi_data;
        logic [2:0] f;
        int         n;
        int         pick;
        int         drain;

        // directed: register corners, counter edges, ignored codes
        add_item(FUNC_TIMER, REG_LINEAR, 8'h00);          // zero period steps at once
        add_item(FUNC_WRITE, REG_UNUSED, 8'hFF);          // register 1 does nothing
        add_item(FUNC_WRITE, REG_LINEAR, 8'h7F);          // counting on, largest reload
        add_item(FUNC_WRITE, REG_TIMER_LO, 8'hFF);
        add_item(FUNC_WRITE, REG_TIMER_HI, 8'hFF);        // longest period, last table entry
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);        // linear reload
        add_item(FUNC_TIMER, REG_TIMER_HI, 8'hFF);
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);
        add_item(FUNC_WRITE, REG_TIMER_LO, 8'h00);
        add_item(FUNC_WRITE, REG_TIMER_HI, 8'h08);        // period zero, longest length
        add_item(FUNC_TIMER, REG_LINEAR, 8'h00);
        add_item(FUNC_TIMER, REG_LINEAR, 8'h00);
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);
        add_item(FUNC_WRITE, REG_LINEAR, 8'h80);          // halt: counting off, reload zero
        add_item(FUNC_WRITE, REG_TIMER_HI, 8'h18);        // shortest length
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);        // reload to zero, flag kept
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);           // halted, no decrement
        add_item(FUNC_WRITE, REG_LINEAR, 8'h01);
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);           // length reaches zero
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);           // stays at zero
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);        // linear reaches zero
        add_item(FUNC_UNUSED_HI, REG_TIMER_HI, 8'hFF);
        add_item(FUNC_UNUSED_LO, REG_LINEAR, 8'h00);

        // random: note setups followed by clocked runs, with some noise mixed in
        while (pending_events.size() < 1830) begin
            lin_data[7]   = ($urandom_range(0, 3) == 0);
            lin_data[6:0] = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(1, 8))
                                                        : 7'($urandom);
            hi_data[7:3]  = 5'($urandom);
            hi_data[2:0]  = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd0;
            add_item(FUNC_WRITE, REG_LINEAR, lin_data);
            add_item(FUNC_WRITE, REG_TIMER_LO, ($urandom_range(0, 3) == 0)
                                               ? 8'($urandom) : 8'($urandom_range(0, 5)));
            add_item(FUNC_WRITE, REG_TIMER_HI, hi_data);
            add_item(FUNC_QUARTER, 2'($urandom), 8'($urandom));
            n = $urandom_range(8, 48);
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    f = FUNC_TIMER;
                end else if (pick < 74) begin
                    f = FUNC_QUARTER;
                end else if (pick < 86) begin
                    f = FUNC_HALF;
                end else if (pick < 94) begin
                    f = FUNC_WRITE;
                end else if (pick < 97) begin
                    f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
                end else begin
                    // any code but silence, which would mute the rest of the run
                    f = 3'($urandom);
                    if (f == FUNC_SILENCE) begin
                        f = FUNC_TIMER;
                    end
                end
                add_item(f, 2'($urandom), 8'($urandom));
            end
        end

        // silence last: it mutes for good, length loads still show
        add_item(FUNC_SILENCE, 2'($urandom), 8'($urandom));
        add_item(FUNC_WRITE, REG_LINEAR, 8'h10);
        add_item(FUNC_WRITE, REG_TIMER_HI, 8'($urandom));
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);
        for (int k = 0; k < 12; k++) begin
            add_item(FUNC_TIMER, 2'($urandom), 8'($urandom));
        end
        add_item(FUNC_HALF, REG_LINEAR, 8'h00);
        add_item(FUNC_SILENCE, REG_TIMER_HI, 8'hFF);
        add_item(FUNC_QUARTER, REG_LINEAR, 8'h00);
        total_items = pending_events.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (items_taken == total_items);
        drain = 0;
        while (expected_levels.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (5) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_levels.size()));
        end

        if (error_count == 0) begin
            $display("triangle_wave_channel_tb passed");
        end else begin
            $display("triangle_wave_channel_tb failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/twc_pkg.sv
src/twc_core.sv
src/triangle_wave_channel.sv
bench/triangle_wave_channel_tb.sv
